@@ rtl/adll_pkg.sv @@
package adll_pkg;

   // field widths of the request and result items
   localparam int OP_W        = 4;
   localparam int SLOT_W      = 3;
   localparam int PAYLOAD_W   = 32;
   localparam int STATUS_W    = 3;
   localparam int RSP_SLOT_W  = 3;
   localparam int COUNT_W     = 4;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 48;

   localparam int SLOTS_DEFAULT      = 8;
   localparam int DATA_WIDTH_DEFAULT = 32;

   typedef enum logic [OP_W-1:0] {
      OP_ADD_FIRST = 4'd0,
      OP_ADD_AFTER = 4'd1,
      OP_ADD_LAST  = 4'd2,
      OP_DEL_FIRST = 4'd3,
      OP_DEL_AFTER = 4'd4,
      OP_DEL_LAST  = 4'd5,
      OP_DEL_ALL   = 4'd6,
      OP_COUNT     = 4'd7,
      OP_WALK_FWD  = 4'd8,
      OP_WALK_REV  = 4'd9
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_NO_SUCC  = 3'd3,
      ST_NOT_USED = 3'd4
   } status_type;

   // one result handed from the sequencer to the output register
   typedef struct packed {
      logic                  valid;
      status_type            status;
      logic [RSP_SLOT_W-1:0] slot;
      logic [COUNT_W-1:0]    count;
      logic                  last;
      logic                  walk;
   } rsp_push_type;

endpackage

@@ rtl/array_doubly_linked_list.sv @@
// Doubly linked list in a pool of SLOTS entries, linked by slot index.
// Request channel (req_*): one transfer carries an operation code, a slot
// and a payload word. Result channel (rsp_*): each request gives one result
// with rsp_tlast set, except a walk, which gives one result per entry in list
// order with rsp_tlast on the final one.
// Requests are taken one at a time; req_tready is low while one is in work.
// Steps from request to result: count, delete all and most failed requests
// go from decode to the result; delete after reads the slot's link, ends
// there with no successor, else reads the successor's links and unlinks it;
// add first/last write the new slot, then link it in; delete first/last read
// the links, then unlink; add after reads the links, writes the new slot,
// then links it in. The link memories are each read or written once per cycle
// through one sequencer; a walk follows one link per cycle unless the receiver stalls.
// A result waits in the output register while the receiver stalls; the
// sequencer holds until that register is free again.
// Reset empties the list: a per-slot use bitmap marks all slots free, so the
// link and data memories need no clearing pass.
module array_doubly_linked_list #(
   parameter int SLOTS      = adll_pkg::SLOTS_DEFAULT,
   parameter int DATA_WIDTH = adll_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // op [3:0], slot [6:4], payload [38:7], zero [39]
   input  logic [adll_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // status [2:0], entry_data [34:3], entry_slot [37:35], entry_count [41:38],
   // zero [47:42]
   output logic [adll_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                               rsp_tlast
);
   import adll_pkg::*;

   localparam int IW    = $clog2(SLOTS);
   localparam int LW    = $clog2(SLOTS + 2);
   localparam int PAD_W = RSP_TDATA_W - (STATUS_W + PAYLOAD_W + RSP_SLOT_W + COUNT_W);

   localparam int OP_LSB      = 0;
   localparam int SLOT_LSB    = OP_LSB + OP_W;
   localparam int PAYLOAD_LSB = SLOT_LSB + SLOT_W;

   rsp_push_type            push;
   logic                    rsp_free;
   logic                    rd_en;
   logic [IW-1:0]           rd_addr;
   logic [LW-1:0]           next_rd, prev_rd;
   logic [DATA_WIDTH-1:0]   data_rd;
   logic                    nx_we, pv_we, dt_we;
   logic [IW-1:0]           nx_waddr, pv_waddr, dt_waddr;
   logic [LW-1:0]           nx_wdata, pv_wdata;

   logic [DATA_WIDTH-1:0]   payload_ff;
   logic                    rsp_valid_ff;
   status_type              rsp_status_ff;
   logic [PAYLOAD_W-1:0]    rsp_data_ff;
   logic [RSP_SLOT_W-1:0]   rsp_slot_ff;
   logic [COUNT_W-1:0]      rsp_count_ff;
   logic                    rsp_last_ff;

   adll_seq #(
      .SLOTS (SLOTS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_op    (req_tdata[SLOT_LSB-1:OP_LSB]),
      .req_slot  (req_tdata[PAYLOAD_LSB-1:SLOT_LSB]),
      .rsp_free  (rsp_free),
      .push      (push),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .next_rd   (next_rd),
      .prev_rd   (prev_rd),
      .nx_we     (nx_we),
      .nx_waddr  (nx_waddr),
      .nx_wdata  (nx_wdata),
      .pv_we     (pv_we),
      .pv_waddr  (pv_waddr),
      .pv_wdata  (pv_wdata),
      .dt_we     (dt_we),
      .dt_waddr  (dt_waddr)
   );

   adll_ram #(
      .DEPTH (SLOTS),
      .WIDTH (LW)
   ) u_next_ram (
      .clock   (clock),
      .wr_en   (nx_we),
      .wr_addr (nx_waddr),
      .wr_data (nx_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (next_rd)
   );

   adll_ram #(
      .DEPTH (SLOTS),
      .WIDTH (LW)
   ) u_prev_ram (
      .clock   (clock),
      .wr_en   (pv_we),
      .wr_addr (pv_waddr),
      .wr_data (pv_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (prev_rd)
   );

   adll_ram #(
      .DEPTH (SLOTS),
      .WIDTH (DATA_WIDTH)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (dt_we),
      .wr_addr (dt_waddr),
      .wr_data (payload_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (data_rd)
   );

   // hold the payload of the request in work
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         payload_ff <= DATA_WIDTH'(req_tdata[PAYLOAD_LSB+PAYLOAD_W-1:PAYLOAD_LSB]);
      end
   end

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (push.valid) begin
         rsp_status_ff <= push.status;
         rsp_data_ff   <= push.walk ? PAYLOAD_W'(data_rd) : '0;
         rsp_slot_ff   <= push.slot;
         rsp_count_ff  <= push.count;
         rsp_last_ff   <= push.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_count_ff, rsp_slot_ff, rsp_data_ff, rsp_status_ff};

`ifndef ASSERT_OFF
   // the sequencer takes one request at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while the previous one is in work");

   // a result never overwrites one that has not been transferred
   a_push_into_free: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> rsp_free)
      else $error("result pushed into an occupied output register");

   // a failed request ends with its single result
   a_fail_is_last: assert property (@(posedge clock) disable iff (reset)
      push.valid && push.status != ST_OK |-> push.last && !push.walk)
      else $error("error result not marked last");
`endif

endmodule

@@ rtl/adll_ram.sv @@
module adll_ram #(
   parameter int DEPTH = adll_pkg::SLOTS_DEFAULT,
   parameter int WIDTH = adll_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   import adll_pkg::*;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/adll_seq.sv @@
module adll_seq #(
   parameter int SLOTS = adll_pkg::SLOTS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [adll_pkg::OP_W-1:0]      req_op,
   input  logic [adll_pkg::SLOT_W-1:0]    req_slot,
   input  logic                           rsp_free,
   output adll_pkg::rsp_push_type         push,
   output logic                           rd_en,
   output logic [$clog2(SLOTS)-1:0]       rd_addr,
   input  logic [$clog2(SLOTS+2)-1:0]     next_rd,
   input  logic [$clog2(SLOTS+2)-1:0]     prev_rd,
   output logic                           nx_we,
   output logic [$clog2(SLOTS)-1:0]       nx_waddr,
   output logic [$clog2(SLOTS+2)-1:0]     nx_wdata,
   output logic                           pv_we,
   output logic [$clog2(SLOTS)-1:0]       pv_waddr,
   output logic [$clog2(SLOTS+2)-1:0]     pv_wdata,
   output logic                           dt_we,
   output logic [$clog2(SLOTS)-1:0]       dt_waddr
);
   import adll_pkg::*;

   localparam int IW = $clog2(SLOTS);
   localparam int LW = $clog2(SLOTS + 2);
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [LW-1:0] END_LINK = LW'(SLOTS);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_SUCC_RD,
      S_LINK_RD,
      S_ADD_WR,
      S_ADD_FIX,
      S_DEL_WR,
      S_WALK,
      S_RESP
   } state_type;

   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [LW-1:0]      head_ff, head_in;
   logic [LW-1:0]      tail_ff, tail_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [SLOTS-1:0]   used_ff, used_in;
   logic [IW-1:0]      lowfree_ff, lowfree_in;
   status_type         status_ff, status_in;
   logic [IW-1:0]      rslot_ff, rslot_in;
   logic [LW-1:0]      p_ff, p_in;
   logic [LW-1:0]      s_ff, s_in;
   logic [IW-1:0]      cur_ff, cur_in;

   logic               full;
   logic               slot_ok;
   logic [LW-1:0]      nx_link;
   logic               walk_end;

   // lowest free slot, registered; the bitmap settles well before the next add
   always_comb begin
      lowfree_in = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            lowfree_in = IW'(i);
         end
      end
   end

   assign full     = (count_ff == CW'(SLOTS));
   assign slot_ok  = (32'(slot_ff) < 32'(SLOTS)) && used_ff[IW'(slot_ff)];
   assign nx_link  = (op_ff == OP_WALK_REV) ? prev_rd : next_rd;
   assign walk_end = (nx_link == END_LINK);

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      slot_in   = slot_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      used_in   = used_ff;
      status_in = status_ff;
      rslot_in  = rslot_ff;
      p_in      = p_ff;
      s_in      = s_ff;
      cur_in    = cur_ff;
      req_ready = (state_ff == S_IDLE);
      rd_en     = 1'b0;
      rd_addr   = cur_ff;
      nx_we     = 1'b0;
      nx_waddr  = lowfree_ff;
      nx_wdata  = s_ff;
      pv_we     = 1'b0;
      pv_waddr  = lowfree_ff;
      pv_wdata  = p_ff;
      dt_we     = 1'b0;
      dt_waddr  = lowfree_ff;
      push      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = op_type'(req_op);
               slot_in  = req_slot;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            rslot_in  = '0;
            status_in = ST_OK;
            state_in  = S_RESP;
            unique case (op_ff) inside
               OP_ADD_FIRST, OP_ADD_LAST: begin
                  if (full) begin
                     status_in = ST_FULL;
                  end else begin
                     state_in = S_ADD_WR;
                     if (op_ff == OP_ADD_FIRST || head_ff == END_LINK) begin
                        p_in = END_LINK;
                        s_in = head_ff;
                     end else begin
                        p_in = tail_ff;
                        s_in = END_LINK;
                     end
                  end
               end
               OP_ADD_AFTER: begin
                  if (full) begin
                     status_in = ST_FULL;
                  end else if (!slot_ok) begin
                     status_in = ST_NOT_USED;
                  end else begin
                     p_in     = LW'(slot_ff);
                     rd_en    = 1'b1;
                     rd_addr  = IW'(slot_ff);
                     state_in = S_LINK_RD;
                  end
               end
               OP_DEL_FIRST, OP_DEL_LAST: begin
                  if (head_ff == END_LINK) begin
                     status_in = ST_EMPTY;
                  end else begin
                     cur_in   = (op_ff == OP_DEL_FIRST) ? IW'(head_ff) : IW'(tail_ff);
                     rd_en    = 1'b1;
                     rd_addr  = cur_in;
                     state_in = S_LINK_RD;
                  end
               end
               OP_DEL_AFTER: begin
                  if (!slot_ok) begin
                     status_in = ST_NOT_USED;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = IW'(slot_ff);
                     state_in = S_SUCC_RD;
                  end
               end
               OP_DEL_ALL: begin
                  used_in  = '0;
                  head_in  = END_LINK;
                  tail_in  = END_LINK;
                  count_in = '0;
               end
               OP_WALK_FWD, OP_WALK_REV: begin
                  if (head_ff == END_LINK) begin
                     status_in = ST_EMPTY;
                  end else begin
                     cur_in   = (op_ff == OP_WALK_FWD) ? IW'(head_ff) : IW'(tail_ff);
                     rd_en    = 1'b1;
                     rd_addr  = cur_in;
                     state_in = S_WALK;
                  end
               end
               default: begin
                  // count and unused codes change nothing
               end
            endcase
         end

         S_SUCC_RD: begin
            if (next_rd == END_LINK) begin
               status_in = ST_NO_SUCC;
               state_in  = S_RESP;
            end else begin
               cur_in   = IW'(next_rd);
               rd_en    = 1'b1;
               rd_addr  = cur_in;
               state_in = S_LINK_RD;
            end
         end

         S_LINK_RD: begin
            if (op_ff == OP_ADD_AFTER) begin
               s_in     = next_rd;
               state_in = S_ADD_WR;
            end else begin
               p_in     = prev_rd;
               s_in     = next_rd;
               state_in = S_DEL_WR;
            end
         end

         S_ADD_WR: begin
            nx_we               = 1'b1;
            pv_we               = 1'b1;
            dt_we               = 1'b1;
            used_in[lowfree_ff] = 1'b1;
            count_in            = count_ff + CW'(1);
            rslot_in            = lowfree_ff;
            state_in            = S_ADD_FIX;
         end

         S_ADD_FIX: begin
            // hook the new slot into its neighbors
            if (p_ff == END_LINK) begin
               head_in = LW'(rslot_ff);
            end else begin
               nx_we    = 1'b1;
               nx_waddr = IW'(p_ff);
               nx_wdata = LW'(rslot_ff);
            end
            if (s_ff == END_LINK) begin
               tail_in = LW'(rslot_ff);
            end else begin
               pv_we    = 1'b1;
               pv_waddr = IW'(s_ff);
               pv_wdata = LW'(rslot_ff);
            end
            state_in = S_RESP;
         end

         S_DEL_WR: begin
            if (p_ff == END_LINK) begin
               head_in = s_ff;
            end else begin
               nx_we    = 1'b1;
               nx_waddr = IW'(p_ff);
               nx_wdata = s_ff;
            end
            if (s_ff == END_LINK) begin
               tail_in = p_ff;
            end else begin
               pv_we    = 1'b1;
               pv_waddr = IW'(s_ff);
               pv_wdata = p_ff;
            end
            used_in[cur_ff] = 1'b0;
            count_in        = count_ff - CW'(1);
            state_in        = S_RESP;
         end

         S_WALK: begin
            // emit one entry per cycle; hold the read data while stalled
            if (rsp_free) begin
               push.valid  = 1'b1;
               push.status = ST_OK;
               push.slot   = RSP_SLOT_W'(cur_ff);
               push.count  = COUNT_W'(count_ff);
               push.last   = walk_end;
               push.walk   = 1'b1;
               if (walk_end) begin
                  state_in = S_IDLE;
               end else begin
                  cur_in  = IW'(nx_link);
                  rd_en   = 1'b1;
                  rd_addr = cur_in;
               end
            end
         end

         S_RESP: begin
            if (rsp_free) begin
               push.valid  = 1'b1;
               push.status = status_ff;
               push.slot   = RSP_SLOT_W'(rslot_ff);
               push.count  = COUNT_W'(count_ff);
               push.last   = 1'b1;
               push.walk   = 1'b0;
               state_in    = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= END_LINK;
         tail_ff  <= END_LINK;
         count_ff <= '0;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         used_ff  <= used_in;
      end
      op_ff      <= op_in;
      slot_ff    <= slot_in;
      lowfree_ff <= lowfree_in;
      status_ff  <= status_in;
      rslot_ff   <= rslot_in;
      p_ff       <= p_in;
      s_ff       <= s_in;
      cur_ff     <= cur_in;
   end

endmodule
